### rtl/rlf_pkg.sv
package rlf_pkg;

  // Widths of the datapath
  localparam int N_BITS   = 20;
  localparam int CARRY_W  = N_BITS + 4;
  localparam int CNT_W    = N_BITS + 1;
  localparam int DIGIT_W  = 4;
  localparam int ROW_W    = 2;

  // Reciprocal of ten for the divide unit: q = (x * RECIP10) >> RECIP_SH
  localparam int RECIP_SH = CARRY_W + 3;
  localparam int RECIP_W  = CARRY_W;
  localparam logic [RECIP_W-1:0] RECIP10 =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);
  localparam int PROD_W   = CARRY_W + RECIP_W;
  localparam int QUOT_W   = PROD_W - RECIP_SH;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Table rows, chosen by the last digit of n
  localparam logic [ROW_W-1:0] ROW_END1 = 2'd0;
  localparam logic [ROW_W-1:0] ROW_END3 = 2'd1;
  localparam logic [ROW_W-1:0] ROW_END7 = 2'd2;
  localparam logic [ROW_W-1:0] ROW_END9 = 2'd3;

  typedef logic [N_BITS-1:0]  value_t;
  typedef logic [CARRY_W-1:0] carry_t;
  typedef logic [CNT_W-1:0]   count_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [ROW_W-1:0]   row_t;

  // Multiplier digit for a given last digit of n and needed product digit
  function automatic digit_t digit_pick(input row_t row, input digit_t col);
    digit_t d;
    d = '0;
    case (row)
      ROW_END1: d = col;
      ROW_END3: begin
        case (col)
          4'd1: d = 4'd7;  4'd2: d = 4'd4;  4'd3: d = 4'd1;
          4'd4: d = 4'd8;  4'd5: d = 4'd5;  4'd6: d = 4'd2;
          4'd7: d = 4'd9;  4'd8: d = 4'd6;  4'd9: d = 4'd3;
          default: d = 4'd0;
        endcase
      end
      ROW_END7: begin
        case (col)
          4'd1: d = 4'd3;  4'd2: d = 4'd6;  4'd3: d = 4'd9;
          4'd4: d = 4'd2;  4'd5: d = 4'd5;  4'd6: d = 4'd8;
          4'd7: d = 4'd1;  4'd8: d = 4'd4;  4'd9: d = 4'd7;
          default: d = 4'd0;
        endcase
      end
      ROW_END9: begin
        case (col)
          4'd1: d = 4'd9;  4'd2: d = 4'd8;  4'd3: d = 4'd7;
          4'd4: d = 4'd6;  4'd5: d = 4'd5;  4'd6: d = 4'd4;
          4'd7: d = 4'd3;  4'd8: d = 4'd2;  4'd9: d = 4'd1;
          default: d = 4'd0;
        endcase
      end
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

### rtl/rlf_in_if.sv
interface rlf_in_if;
  logic                 valid;
  logic                 ready;
  rlf_pkg::value_t      value_n;

  modport source (output valid, output value_n, input ready);
  modport sink   (input valid, input value_n, output ready);
endinterface

### rtl/rlf_out_if.sv
interface rlf_out_if;
  logic                 valid;
  logic                 ready;
  rlf_pkg::value_t      repunit_length;
  logic                 status;

  modport source (output valid, output repunit_length, output status, input ready);
  modport sink   (input valid, input repunit_length, input status, output ready);
endinterface

### rtl/repunit_length_finder_top.sv
// Searches the multiplier digits of n one at a time until the running carry dies out; an n whose
// last digit is not 1, 3, 7 or 9 skips the search and returns status INVALID.
// A new request is taken only in idle, after the last result is loaded; each multiplier digit
// goes through multiply-add, divide by ten and remainder, the last two on the shared divide-by-ten unit.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops any result.
module repunit_length_finder_top (
  input  logic          clk,
  input  logic          rst_n,
  rlf_in_if.sink        in_ch,
  rlf_out_if.source     out_ch
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CHK  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_MOD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  rlf_pkg::value_t         n_r, n_nxt;
  rlf_pkg::carry_t         carry_r, carry_nxt;
  rlf_pkg::count_t         count_r, count_nxt;
  rlf_pkg::digit_t         need_r, need_nxt;
  rlf_pkg::row_t           row_r, row_nxt;
  logic                    bad_r, bad_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rlf_pkg::value_t         out_len_r, out_len_nxt;
  logic                    out_status_r, out_status_nxt;

  // Shared divide-by-ten unit
  rlf_pkg::carry_t                 div_x;
  logic [rlf_pkg::PROD_W-1:0]      div_prod;
  logic [rlf_pkg::QUOT_W-1:0]      div_q;
  logic [rlf_pkg::QUOT_W-1:0]      div_q10;
  rlf_pkg::digit_t                 div_rem;

  rlf_pkg::digit_t                 pick_d;
  rlf_pkg::carry_t                 mul_add;

  // Select the unit operand: n during the digit check, else the carry
  always_comb begin
    div_x    = (state_r == ST_CHK) ?
               rlf_pkg::CARRY_W'(n_r) : carry_r;
    div_prod = rlf_pkg::PROD_W'(div_x) * rlf_pkg::PROD_W'(rlf_pkg::RECIP10);
    div_q    = div_prod[rlf_pkg::PROD_W-1:rlf_pkg::RECIP_SH];
    div_q10  = (div_q << 3) + (div_q << 1);
    div_rem  = div_x[rlf_pkg::DIGIT_W-1:0] - div_q10[rlf_pkg::DIGIT_W-1:0];
  end

  // Multiply-add for the next multiplier digit
  always_comb begin
    pick_d  = rlf_pkg::digit_pick(row_r, need_r);
    mul_add = carry_r + (rlf_pkg::CARRY_W'(pick_d) * rlf_pkg::CARRY_W'(n_r));
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.repunit_length = out_len_r;
  assign out_ch.status         = out_status_r;

  // Sequence the digit search
  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    carry_nxt      = carry_r;
    count_nxt      = count_r;
    need_nxt       = need_r;
    row_nxt        = row_r;
    bad_nxt        = bad_r;
    out_valid_nxt  = out_valid_r;
    out_len_nxt    = out_len_r;
    out_status_nxt = out_status_r;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          n_nxt     = in_ch.value_n;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        carry_nxt = '0;
        count_nxt = rlf_pkg::CNT_W'(1);
        need_nxt  = rlf_pkg::DIGIT_W'(1);
        bad_nxt   = 1'b0;
        state_nxt = ST_MUL;
        case (div_rem)
          4'd1: row_nxt = rlf_pkg::ROW_END1;
          4'd3: row_nxt = rlf_pkg::ROW_END3;
          4'd7: row_nxt = rlf_pkg::ROW_END7;
          4'd9: row_nxt = rlf_pkg::ROW_END9;
          default: begin
            row_nxt   = rlf_pkg::ROW_END1;
            bad_nxt   = 1'b1;
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_MUL: begin
        carry_nxt = mul_add;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        carry_nxt = rlf_pkg::CARRY_W'(div_q);
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        // Stop on zero carry or at the digit cap
        if (carry_r == '0 || count_r[rlf_pkg::CNT_W-1]) begin
          state_nxt = ST_DONE;
        end else begin
          need_nxt  = (div_rem == 4'd0) ? 4'd1 :
                      (div_rem == 4'd1) ? 4'd0 : 4'd11 - div_rem;
          count_nxt = count_r + rlf_pkg::CNT_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        // Load the result when the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_len_nxt    = bad_r ? '0 : count_r[rlf_pkg::N_BITS-1:0];
          out_status_nxt = bad_r ? rlf_pkg::STATUS_INVALID : rlf_pkg::STATUS_OK;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    carry_r      <= carry_nxt;
    count_r      <= count_nxt;
    need_r       <= need_nxt;
    row_r        <= row_nxt;
    bad_r        <= bad_nxt;
    out_len_r    <= out_len_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

### tb/rlf_length_checker.sv
`timescale 1ns / 1ps

module rlf_length_checker (
  input  logic        clk,
  input  logic        rst_n,
  rlf_in_if           in_ch,
  rlf_out_if          out_ch,
  output int unsigned error_count,
  output int unsigned lengths_pending
);

  typedef struct packed {
    rlf_pkg::value_t value_n;
    rlf_pkg::value_t repunit_length;
    logic            status;
  } length_result_t;

  length_result_t length_queue[$];
  int unsigned    mismatches = 0;
  int unsigned    queue_depth = 0;

  assign error_count     = mismatches;
  assign lengths_pending = queue_depth;

  // Walk the multiplier digits of n until the running carry dies out
  function automatic length_result_t repunit_length_of(input rlf_pkg::value_t n);
    length_result_t              r;
    logic [rlf_pkg::CARRY_W+3:0] sum;
    rlf_pkg::carry_t             carry;
    rlf_pkg::count_t             digits;
    rlf_pkg::digit_t             last;
    rlf_pkg::digit_t             need;
    rlf_pkg::digit_t             mult;
    logic                        done;
    r.value_n        = n;
    r.repunit_length = '0;
    r.status         = rlf_pkg::STATUS_INVALID;
    last = rlf_pkg::digit_t'(n % 10);
    if (last == 4'd1 || last == 4'd3 || last == 4'd7 || last == 4'd9) begin
      carry  = '0;
      digits = rlf_pkg::count_t'(1);
      need   = rlf_pkg::digit_t'(1);
      done   = 1'b0;
      while (!done) begin
        // pick the digit whose product with the last digit of n ends in need
        mult = '0;
        for (int d = 0; d < 10; d++) begin
          if ((d * last) % 10 == need) mult = rlf_pkg::digit_t'(d);
        end
        sum   = carry + mult * n;
        carry = rlf_pkg::carry_t'(sum / 10);
        if (carry == 0 || digits >= rlf_pkg::count_t'(1 << rlf_pkg::N_BITS)) begin
          done = 1'b1;
        end else begin
          need   = rlf_pkg::digit_t'((11 - carry % 10) % 10);
          digits = digits + 1'b1;
        end
      end
      r.repunit_length = rlf_pkg::value_t'(digits);
      r.status         = rlf_pkg::STATUS_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Match each result against the oldest pending request, then log new requests
  always @(posedge clk) begin
    length_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (length_queue.size() == 0) begin
          report_mismatch($sformatf("result with no request pending: length %0d status %0b",
                                    out_ch.repunit_length, out_ch.status));
        end else begin
          want = length_queue.pop_front();
          if (out_ch.repunit_length !== want.repunit_length)
            report_mismatch($sformatf("n=%0d length got %0d want %0d", want.value_n,
                                      out_ch.repunit_length, want.repunit_length));
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("n=%0d status got %0b want %0b", want.value_n,
                                      out_ch.status, want.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        length_queue.push_back(repunit_length_of(in_ch.value_n));
      end
      queue_depth <= length_queue.size();
    end
  end

endmodule

### tb/tb_repunit_length_finder_top.sv
`timescale 1ns / 1ps

module tb_repunit_length_finder_top;

  localparam int          CYCLE_LIMIT     = 2_000_000;
  localparam int          DRAIN_CYCLES    = 64;
  localparam int          DIRECTED_COUNT  = 24;
  localparam int          RANDOM_REQUESTS = 76;
  localparam int          HOLD_CYCLES     = 400;
  localparam int          HOLD_AFTER      = 30;
  localparam int unsigned VALUE_MAX       = (1 << rlf_pkg::N_BITS) - 1;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned error_count;
  int unsigned lengths_pending;
  int unsigned cycle_cnt     = 0;
  int unsigned requests_sent = 0;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;

  rlf_in_if  in_ch ();
  rlf_out_if out_ch ();

  repunit_length_finder_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rlf_length_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .error_count     (error_count),
    .lengths_pending (lengths_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Numbers coprime to ten whose repunit length is short, some near the top of the range
  function automatic rlf_pkg::value_t short_cycle_value(input int idx);
    case (idx)
      0:       return rlf_pkg::value_t'(1001001);
      1:       return rlf_pkg::value_t'(999001);
      2:       return rlf_pkg::value_t'(1000001);
      3:       return rlf_pkg::value_t'(900991);
      4:       return rlf_pkg::value_t'(372731);
      5:       return rlf_pkg::value_t'(333667);
      6:       return rlf_pkg::value_t'(366337);
      7:       return rlf_pkg::value_t'(100001);
      8:       return rlf_pkg::value_t'(4187);
      default: return rlf_pkg::value_t'(1001);
    endcase
  endfunction

  function automatic rlf_pkg::value_t directed_value(input int idx);
    case (idx)
      0:       return rlf_pkg::value_t'(0);
      1:       return rlf_pkg::value_t'(1);
      2:       return rlf_pkg::value_t'(2);
      3:       return rlf_pkg::value_t'(4);
      4:       return rlf_pkg::value_t'(5);
      5:       return rlf_pkg::value_t'(6);
      6:       return rlf_pkg::value_t'(8);
      7:       return rlf_pkg::value_t'(10);
      8:       return rlf_pkg::value_t'(3);
      9:       return rlf_pkg::value_t'(7);
      10:      return rlf_pkg::value_t'(9);
      11:      return rlf_pkg::value_t'(11);
      12:      return rlf_pkg::value_t'(21);
      13:      return rlf_pkg::value_t'(41);
      14:      return rlf_pkg::value_t'(99);
      15:      return rlf_pkg::value_t'(VALUE_MAX);
      16:      return rlf_pkg::value_t'(VALUE_MAX - 1);
      17:      return rlf_pkg::value_t'(VALUE_MAX - 5);
      default: return short_cycle_value(idx - 18);
    endcase
  endfunction

  // Mostly small valid n with random content, a few large ones, the rest bad last digits
  function automatic rlf_pkg::value_t random_request();
    int unsigned pick;
    int unsigned base;
    int unsigned digit;
    pick = $urandom_range(99);
    if (pick < 15) begin
      base = $urandom_range(VALUE_MAX);
      base = base - base % 10;
      case ($urandom_range(5))
        0:       digit = 0;
        1:       digit = 2;
        2:       digit = 4;
        3:       digit = 5;
        4:       digit = 6;
        default: digit = 8;
      endcase
      if (base + digit > VALUE_MAX) base = base - 10;
      return rlf_pkg::value_t'(base + digit);
    end else if (pick < 25) begin
      return short_cycle_value($urandom_range(9));
    end
    case ($urandom_range(3))
      0:       digit = 1;
      1:       digit = 3;
      2:       digit = 7;
      default: digit = 9;
    endcase
    return rlf_pkg::value_t'($urandom_range(99) * 10 + digit);
  endfunction

  // Offer one request, idling at random outside the calm window, and hold until taken
  task automatic send_request(input rlf_pkg::value_t v);
    while (!(requests_sent >= 60 && requests_sent < 85) && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value_n <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Drop ready at random, with one long hold-off and one calm window
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        out_ch.ready <= 1'b0;
        hold_left    <= HOLD_CYCLES;
        hold_done    <= 1'b1;
      end else begin
        out_ch.ready <= (results_seen >= 60 && results_seen < 85) || ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.value_n <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_COUNT; i++) send_request(directed_value(i));
    for (int i = 0; i < RANDOM_REQUESTS; i++) send_request(random_request());
    in_ch.valid <= 1'b0;

    // Drain every pending result, then watch for strays
    do @(posedge clk); while (lengths_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
